// ===== hdl/kmp_pkg.sv =====
// ============================================================================
// kmp_pkg - keyboard macro player shared types
// Item structs, action and entry-type codes, modifier decode.
// ============================================================================
`default_nettype none

package kmp_pkg;

    // action codes of an input item
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_POLL  = 2'd1;
    localparam logic [1:0] ACT_SENT  = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    // program entry types
    localparam logic [2:0] ET_END    = 3'd0;
    localparam logic [2:0] ET_DOWN   = 3'd1;
    localparam logic [2:0] ET_UP     = 3'd2;
    localparam logic [2:0] ET_TAP    = 3'd3;
    localparam logic [2:0] ET_DELAY  = 3'd4;
    localparam logic [2:0] ET_PAUSE  = 3'd5;
    localparam logic [2:0] ET_UNPROG = 3'd6;
    localparam logic [2:0] ET_NOP    = 3'd7;

    localparam logic [7:0] DEFAULT_UNIT_MS = 8'd10;

    // program entry: type above value
    localparam int ENTRY_W = 11;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] switch_levels;
        logic [2:0] entry_slot;
        logic [4:0] entry_position;
        logic [2:0] entry_type;
        logic [7:0] entry_value;
    } t_in;

    typedef struct packed {
        logic [3:0] modifier_bits;
        logic [7:0] report_key_0;
        logic [7:0] report_key_1;
        logic [7:0] report_key_2;
        logic [7:0] report_key_3;
        logic [7:0] report_key_4;
        logic [7:0] report_key_5;
        logic       macro_running;
        logic       reset_request;
    } t_out;

    // left ctrl/shift/alt/gui usages 0xE0..0xE3 map to modifier bits 0..3
    function automatic logic [3:0] mod_of(input logic [7:0] key);
        logic [3:0] m;
        m = 4'b0000;
        if (key[7:2] == 6'b111000) begin
            m = 4'b0001 << key[1:0];
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/keyboard_macro_player_core.sv =====
// ============================================================================
// keyboard_macro_player_core - per-switch key macro player
// Steps programmed key macros into a six-key HID report with modifiers.
// ============================================================================
// Every input item gives exactly one result item: its program memory read
// feeds the step stage, whose step and report update land in the output
// register. Program writes, report-sent and tick items are taken one per
// cycle while the output is not stalled and no poll is ahead. A poll item
// holds the input while it sits in the step stage: the step it takes
// writes back the macro state (active macro, step positions, switch
// history, sent flag) that the next poll needs to form its program memory
// address. The output register separates the two sides: a new item is
// still taken while a finished result waits on i_out_stall, as long as
// the step stage is empty. The program store is one RAM of
// SWITCH_COUNT*PROGRAM_DEPTH entries (3-bit type, 8-bit value), written at
// accept of a write item and read at accept of a poll that steps. Its
// contents are undefined after reset and there is no clearing pass: a
// macro must be programmed before it is played. Register 0 (byte address
// 0) holds the delay unit in milliseconds, reset 10; a delay step waits
// until more than value*unit ticks have passed since it first ran.
// ============================================================================
`default_nettype none

module keyboard_macro_player_core #(
    parameter int PROGRAM_DEPTH = 32,
    parameter int SWITCH_COUNT  = 5,
    parameter int REPORT_KEYS   = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input items
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire kmp_pkg::t_in  i_in_item,
    // result items
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output kmp_pkg::t_out      o_out_item,
    // register port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);

    import kmp_pkg::*;

    localparam int MW        = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;
    localparam int PW        = $clog2(PROGRAM_DEPTH + 1);
    localparam int CW        = $clog2(REPORT_KEYS + 1);
    localparam int KW        = (REPORT_KEYS > 1) ? $clog2(REPORT_KEYS) : 1;
    localparam int DEPTH_ALL = SWITCH_COUNT * PROGRAM_DEPTH;
    localparam int AW        = $clog2(DEPTH_ALL);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [7:0] r_unit;
    logic       cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_unit};

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    logic                    r_act_valid;     // a macro is running
    logic [MW-1:0]           r_act_idx;
    logic [PW-1:0]           r_pos [SWITCH_COUNT];
    logic [SWITCH_COUNT-1:0] r_hist;          // switch levels at last edge seen
    logic                    r_sent;
    logic                    r_tap;
    logic                    r_dly;
    logic [31:0]             r_dstart;
    logic [31:0]             r_ms;
    logic [7:0]              r_keys [REPORT_KEYS];
    logic [CW-1:0]           r_cnt;
    logic [3:0]              r_mods;

    // stage 1: item accepted, program read in flight
    logic                    r_s1_valid;
    logic [1:0]              r_s1_act;
    logic                    r_s1_take;       // poll takes a step
    logic                    r_s1_setact;     // poll starts/resumes a macro
    logic [MW-1:0]           r_s1_macro;
    logic [PW-1:0]           r_s1_pos;
    logic [SWITCH_COUNT-1:0] r_s1_hist;
    logic                    r_s1_rreq;

    // output register
    logic                    r_out_valid;
    t_out                    r_out_item;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic s1_adv;
    logic in_acc;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    // a poll in the step stage owns the macro state until it writes back
    assign o_in_stall = !i_rst_n ||
                        (r_s1_valid && ((r_s1_act == ACT_POLL) || !s1_adv));
    assign in_acc     = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // accept stage: decide what a poll does, form program address
    // ------------------------------------------------------------------
    logic [7:0]              lv8;
    logic [SWITCH_COUNT-1:0] lv;
    logic                    sent_eff;
    logic                    d_take;
    logic                    d_setact;
    logic [MW-1:0]           d_macro;
    logic [PW-1:0]           d_pos;
    logic [SWITCH_COUNT-1:0] d_hist;
    logic                    d_press;

    assign lv8 = {3'd0, i_in_item.switch_levels};
    assign lv  = lv8[SWITCH_COUNT-1:0];

    // a report-sent item draining this cycle counts for the poll behind it
    assign sent_eff = r_sent || (r_s1_valid && (r_s1_act == ACT_SENT));

    always_comb begin
        d_take   = 1'b0;
        d_setact = 1'b0;
        d_macro  = r_act_idx;
        d_pos    = r_pos[r_act_idx];
        d_hist   = r_hist;
        d_press  = 1'b0;
        if (r_act_valid) begin
            d_take = sent_eff;
        end else begin
            // first switch whose level differs from its history wins
            for (int i = SWITCH_COUNT - 1; i >= 0; i--) begin
                if (lv[i] != r_hist[i]) begin
                    d_setact = 1'b1;
                    d_macro  = MW'(i);
                    d_press  = lv[i];
                end
            end
            d_take = d_setact;
            if (d_setact) begin
                d_pos  = d_press ? '0 : r_pos[d_macro];
                d_hist = r_hist ^ (SWITCH_COUNT'(1) << d_macro);
            end
        end
    end

    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [ENTRY_W-1:0] mem_q;

    assign mem_we = in_acc && (i_in_item.action == ACT_WRITE) &&
                    (32'(i_in_item.entry_slot) < 32'(SWITCH_COUNT)) &&
                    (32'(i_in_item.entry_position) < 32'(PROGRAM_DEPTH));
    assign mem_waddr = AW'(i_in_item.entry_slot) * AW'(PROGRAM_DEPTH) +
                       AW'(i_in_item.entry_position);
    assign mem_re    = in_acc && (i_in_item.action == ACT_POLL) && d_take;
    assign mem_raddr = AW'(d_macro) * AW'(PROGRAM_DEPTH) + AW'(d_pos);

    kmp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH_ALL)
    ) u_prog (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({i_in_item.entry_type, i_in_item.entry_value}),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // ------------------------------------------------------------------
    // step stage: execute the entry
    // ------------------------------------------------------------------
    logic          st;            // a step executes this cycle
    logic          past_end;
    logic [2:0]    etype;
    logic [7:0]    kv;
    logic          s_press;
    logic          s_release;
    logic          inc;
    logic [PW-1:0] newpos;
    logic          stop;
    logic          n_tap;
    logic          n_dly;
    logic [31:0]   n_dstart;
    logic [31:0]   elapsed;
    logic [15:0]   limit;

    assign st       = s1_adv && (r_s1_act == ACT_POLL) && r_s1_take;
    assign past_end = 32'(r_s1_pos) >= 32'(PROGRAM_DEPTH);
    assign etype    = past_end ? ET_END : mem_q[10:8];
    assign kv       = mem_q[7:0];
    assign elapsed  = r_ms - r_dstart;
    assign limit    = 16'(kv) * 16'(r_unit);

    always_comb begin
        s_press   = 1'b0;
        s_release = 1'b0;
        inc       = 1'b0;
        n_tap     = r_tap;
        n_dly     = r_dly;
        n_dstart  = r_dstart;
        if (st && !past_end) begin
            unique case (etype)
                ET_DOWN: begin
                    s_press = 1'b1;
                    inc     = 1'b1;
                end
                ET_UP: begin
                    s_release = 1'b1;
                    inc       = 1'b1;
                end
                ET_TAP: begin
                    if (r_tap) begin
                        s_release = 1'b1;
                        n_tap     = 1'b0;
                        inc       = 1'b1;
                    end else begin
                        s_press = 1'b1;
                        n_tap   = 1'b1;
                    end
                end
                ET_DELAY: begin
                    if (!r_dly) begin
                        n_dly    = 1'b1;
                        n_dstart = r_ms;
                    end else if (elapsed > {16'd0, limit}) begin
                        n_dly = 1'b0;
                        inc   = 1'b1;
                    end
                end
                ET_END, ET_PAUSE, ET_UNPROG, ET_NOP: begin
                    inc = 1'b1;
                end
                default: begin
                    inc = 1'b0;
                end
            endcase
        end
    end

    assign newpos = r_s1_pos + PW'(inc);
    assign stop   = past_end || (etype == ET_END) || (etype == ET_UNPROG) ||
                    (etype == ET_PAUSE) || (32'(newpos) >= 32'(PROGRAM_DEPTH));

    // held key list: packed from lane 0, a release fills its hole with the last
    logic          found;
    logic [KW-1:0] at;
    logic [KW-1:0] last_idx;
    logic [7:0]    n_keys [REPORT_KEYS];
    logic [CW-1:0] n_cnt;
    logic [3:0]    n_mods;

    assign last_idx = KW'(r_cnt - 1'b1);

    always_comb begin
        found = 1'b0;
        at    = '0;
        for (int j = 0; j < REPORT_KEYS; j++) begin
            if (!found && (CW'(j) < r_cnt) && (r_keys[j] == kv)) begin
                found = 1'b1;
                at    = KW'(j);
            end
        end
        n_keys = r_keys;
        n_cnt  = r_cnt;
        n_mods = r_mods;
        if (s_press) begin
            if ((kv != 8'd0) && !found && (r_cnt < CW'(REPORT_KEYS))) begin
                n_keys[KW'(r_cnt)] = kv;
                n_cnt              = r_cnt + 1'b1;
            end
            n_mods = r_mods | mod_of(kv);
        end
        if (s_release) begin
            if (found) begin
                n_keys[at]       = r_keys[last_idx];
                n_keys[last_idx] = 8'd0;
                n_cnt            = r_cnt - 1'b1;
            end
            n_mods = r_mods & ~mod_of(kv);
        end
    end

    // running flag after this item
    logic          n_act_valid;
    logic [MW-1:0] n_act_idx;

    always_comb begin
        n_act_valid = r_act_valid;
        n_act_idx   = r_act_idx;
        if (s1_adv && (r_s1_act == ACT_POLL)) begin
            if (r_s1_setact) begin
                n_act_valid = 1'b1;
                n_act_idx   = r_s1_macro;
            end
            if (r_s1_take && stop) begin
                n_act_valid = 1'b0;
            end
        end
    end

    // result item
    logic [7:0] keys6 [6];
    t_out       n_out;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            keys6[k] = 8'd0;
        end
        for (int k = 0; k < REPORT_KEYS; k++) begin
            keys6[k] = n_keys[k];
        end
        n_out.modifier_bits = n_mods;
        n_out.report_key_0  = keys6[0];
        n_out.report_key_1  = keys6[1];
        n_out.report_key_2  = keys6[2];
        n_out.report_key_3  = keys6[3];
        n_out.report_key_4  = keys6[4];
        n_out.report_key_5  = keys6[5];
        n_out.macro_running = n_act_valid;
        n_out.reset_request = (r_s1_act == ACT_POLL) && r_s1_rreq;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit      <= DEFAULT_UNIT_MS;
            r_act_valid <= 1'b0;
            r_act_idx   <= '0;
            for (int i = 0; i < SWITCH_COUNT; i++) begin
                r_pos[i] <= '0;
            end
            r_hist      <= '0;
            r_sent      <= 1'b0;
            r_tap       <= 1'b0;
            r_dly       <= 1'b0;
            r_dstart    <= '0;
            r_ms        <= '0;
            for (int j = 0; j < REPORT_KEYS; j++) begin
                r_keys[j] <= 8'd0;
            end
            r_cnt       <= '0;
            r_mods      <= 4'd0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_unit <= pwdata[7:0];
            end

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            r_act_valid <= n_act_valid;
            r_act_idx   <= n_act_idx;

            if (s1_adv) begin
                unique case (r_s1_act)
                    ACT_SENT: begin
                        r_sent <= 1'b1;
                    end
                    ACT_TICK: begin
                        r_ms <= r_ms + 32'd1;
                    end
                    ACT_POLL: begin
                        r_hist <= r_s1_hist;
                        if (r_s1_take) begin
                            r_sent   <= 1'b0;
                            r_tap    <= n_tap;
                            r_dly    <= n_dly;
                            r_dstart <= n_dstart;
                            r_keys   <= n_keys;
                            r_cnt    <= n_cnt;
                            r_mods   <= n_mods;
                            if (!past_end) begin
                                r_pos[r_s1_macro] <= newpos;
                            end
                        end
                    end
                    ACT_WRITE: begin
                        r_sent <= r_sent;
                    end
                    default: begin
                        r_sent <= r_sent;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_act    <= i_in_item.action;
            r_s1_take   <= d_take;
            r_s1_setact <= d_setact;
            r_s1_macro  <= d_macro;
            r_s1_pos    <= d_pos;
            r_s1_hist   <= d_hist;
            r_s1_rreq   <= i_in_item.switch_levels[0] && i_in_item.switch_levels[4];
        end
        if (s1_adv) begin
            r_out_item <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== hdl/kmp_ram.sv =====
// ============================================================================
// kmp_ram - generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ============================================================================
`default_nettype none

module kmp_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 160
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/kmp_chk.sv =====
// ============================================================================
// kmp_chk - port checker for the keyboard macro player
// Watches the top-level ports over time; bound to the core below.
// ============================================================================
`default_nettype none

module kmp_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire kmp_pkg::t_out o_out_item,
    input wire logic          pready
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a result shows up, when the output was empty, after its item has passed the step stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without an item accepted two cycles earlier");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // held keys stay packed from key 0
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_item.report_key_0 != 8'd0) || (o_out_item.report_key_1 == 8'd0)) &&
            ((o_out_item.report_key_1 != 8'd0) || (o_out_item.report_key_2 == 8'd0)) &&
            ((o_out_item.report_key_2 != 8'd0) || (o_out_item.report_key_3 == 8'd0)) &&
            ((o_out_item.report_key_3 != 8'd0) || (o_out_item.report_key_4 == 8'd0)) &&
            ((o_out_item.report_key_4 != 8'd0) || (o_out_item.report_key_5 == 8'd0)))
        else $error("key list has a hole");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind keyboard_macro_player_core kmp_chk u_kmp_chk (.*);

`default_nettype wire

// ===== bench/kmp_report_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// kmp_report_checker - HID report predictor and comparator
// Watches the item channels and the register port of the macro player,
// keeps its own copy of the player state, predicts one report per accepted
// item and compares every accepted result against the oldest prediction.
// ============================================================================

module kmp_report_checker #(
    parameter logic [2:0] UNIT_ADDR = 3'd0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  kmp_pkg::t_in   i_in_item,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  kmp_pkg::t_out  i_out_item,
    input  logic           i_psel,
    input  logic           i_penable,
    input  logic           i_pwrite,
    input  logic [2:0]     i_paddr,
    input  logic [31:0]    i_pwdata,
    input  logic           i_pready,
    output int             o_errors,
    output int             o_pending
);
    import kmp_pkg::*;

    localparam int         DEPTH    = 32;
    localparam int         SWITCHES = 5;
    localparam int         KEYS     = 6;
    localparam logic [2:0] NO_SW    = 3'd7;

    // player state
    logic [10:0] prog_mem [0:SWITCHES*DEPTH-1];
    logic [5:0]  step_pos [0:SWITCHES-1];
    logic [2:0]  cur_sw;
    logic [7:0]  held [0:KEYS-1];
    int          held_n;
    logic [3:0]  mods;
    bit          tap_half;
    bit          delay_on;
    logic [31:0] delay_t0;
    logic [31:0] ms_now;
    bit          sent_seen;
    logic [4:0]  sw_last;
    logic [7:0]  unit_ms;

    t_out expected_reports [$];
    int   err_n  = 0;

    task automatic reset_player();
        for (int i = 0; i < SWITCHES; i++) step_pos[i] = '0;
        for (int i = 0; i < KEYS; i++) held[i] = '0;
        cur_sw    = NO_SW;
        held_n    = 0;
        mods      = '0;
        tap_half  = 0;
        delay_on  = 0;
        delay_t0  = '0;
        ms_now    = '0;
        sent_seen = 0;
        sw_last   = '0;
        unit_ms   = DEFAULT_UNIT_MS;
    endtask

    // left ctrl/shift/alt/gui
    function automatic logic [3:0] modifier_bit(input logic [7:0] key);
        if (key >= 8'hE0 && key <= 8'hE3) begin
            return 4'b0001 << (key - 8'hE0);
        end
        return 4'b0000;
    endfunction

    function automatic int find_held(input logic [7:0] key);
        for (int i = 0; i < held_n && i < KEYS; i++) begin
            if (held[i] == key) return i;
        end
        return -1;
    endfunction

    task automatic press_key(input logic [7:0] key);
        if (key != 8'h00 && find_held(key) < 0 && held_n < KEYS) begin
            held[held_n] = key;
            held_n++;
        end
        mods = mods | modifier_bit(key);
    endtask

    // a found key is replaced by the last held one
    task automatic release_key(input logic [7:0] key);
        int at;
        at = find_held(key);
        if (at >= 0 && held_n > 0) begin
            held[at]         = held[held_n - 1];
            held[held_n - 1] = 8'h00;
            held_n--;
        end
        mods = mods & ~modifier_bit(key);
    endtask

    task automatic advance_macro();
        logic [5:0]  pos;
        logic [10:0] entry;
        logic [2:0]  kind;
        logic [7:0]  val;
        bit          past;
        logic [31:0] elapsed;
        logic [31:0] wait_ms;
        if (cur_sw >= SWITCHES) begin
            cur_sw = NO_SW;
            return;
        end
        pos   = step_pos[cur_sw];
        past  = (pos >= DEPTH);
        entry = past ? 11'd0 : prog_mem[cur_sw * DEPTH + pos];
        kind  = entry[10:8];
        val   = entry[7:0];
        if (!past) begin
            case (kind)
                ET_DOWN: begin
                    press_key(val);
                    pos++;
                end
                ET_UP: begin
                    release_key(val);
                    pos++;
                end
                ET_TAP: begin
                    if (tap_half) begin
                        release_key(val);
                        tap_half = 0;
                        pos++;
                    end else begin
                        press_key(val);
                        tap_half = 1;
                    end
                end
                ET_DELAY: begin
                    elapsed = ms_now - delay_t0;
                    wait_ms = val * unit_ms;
                    if (!delay_on) begin
                        delay_on = 1;
                        delay_t0 = ms_now;
                    end else if (elapsed > wait_ms) begin
                        delay_on = 0;
                        pos++;
                    end
                end
                default: begin
                    pos++;
                end
            endcase
            step_pos[cur_sw] = pos;
        end
        sent_seen = 0;
        if (past || kind == ET_END || kind == ET_UNPROG || kind == ET_PAUSE
                || pos >= DEPTH) begin
            cur_sw = NO_SW;
        end
    endtask

    // first edge in switch order starts (press) or resumes (release)
    task automatic scan_switches(input logic [4:0] lv);
        bit done;
        done = 0;
        for (int i = 0; i < SWITCHES; i++) begin
            if (!done) begin
                if (lv[i]) begin
                    if (!sw_last[i]) begin
                        sw_last[i]  = 1'b1;
                        cur_sw      = 3'(i);
                        step_pos[i] = '0;
                        advance_macro();
                        done = 1;
                    end
                end else if (sw_last[i]) begin
                    sw_last[i] = 1'b0;
                    cur_sw     = 3'(i);
                    advance_macro();
                    done = 1;
                end
            end
        end
    endtask

    task automatic play_item(input t_in it, output t_out rep);
        bit rst_req;
        rst_req = 0;
        case (it.action)
            ACT_WRITE: begin
                if (it.entry_slot < SWITCHES && it.entry_position < DEPTH) begin
                    prog_mem[it.entry_slot * DEPTH + it.entry_position] =
                        {it.entry_type, it.entry_value};
                end
            end
            ACT_POLL: begin
                rst_req = it.switch_levels[0] && it.switch_levels[4];
                if (cur_sw != NO_SW) begin
                    if (sent_seen) advance_macro();
                end else begin
                    scan_switches(it.switch_levels);
                end
            end
            ACT_SENT: begin
                sent_seen = 1;
            end
            ACT_TICK: begin
                ms_now++;
            end
        endcase
        rep.modifier_bits = mods;
        rep.report_key_0  = held[0];
        rep.report_key_1  = held[1];
        rep.report_key_2  = held[2];
        rep.report_key_3  = held[3];
        rep.report_key_4  = held[4];
        rep.report_key_5  = held[5];
        rep.macro_running = (cur_sw != NO_SW);
        rep.reset_request = rst_req;
    endtask

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            err_n++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, fname, want, got);
        end
    endtask

    task automatic compare_report(input t_out want, input t_out got);
        check_field("modifier_bits", want.modifier_bits, got.modifier_bits);
        check_field("report_key_0", want.report_key_0, got.report_key_0);
        check_field("report_key_1", want.report_key_1, got.report_key_1);
        check_field("report_key_2", want.report_key_2, got.report_key_2);
        check_field("report_key_3", want.report_key_3, got.report_key_3);
        check_field("report_key_4", want.report_key_4, got.report_key_4);
        check_field("report_key_5", want.report_key_5, got.report_key_5);
        check_field("macro_running", want.macro_running, got.macro_running);
        check_field("reset_request", want.reset_request, got.reset_request);
    endtask

    always @(posedge i_clk) begin : watch
        t_out next_rep;
        t_out oldest;
        if (!i_rst_n) begin
            reset_player();
            expected_reports.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == UNIT_ADDR) begin
                unit_ms = i_pwdata[7:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    err_n++;
                    $display("%0t: report with none expected, expected nothing, actual %h",
                             $time, i_out_item);
                end else begin
                    oldest = expected_reports.pop_front();
                    compare_report(oldest, i_out_item);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                play_item(i_in_item, next_rep);
                expected_reports.push_back(next_rep);
            end
        end
        o_errors  <= err_n;
        o_pending <= expected_reports.size();
    end

endmodule

// ===== bench/tb_keyboard_macro_player_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_keyboard_macro_player_core - macro player testbench
// Programs every macro, runs a short directed sequence over most step types,
// then random polls, sent events, ticks and program writes under several
// delay units, with random gaps on the input and stalls on the output. A
// checker beside the block predicts and compares every report.
// ============================================================================

module tb_keyboard_macro_player_core;
    import kmp_pkg::*;

    localparam logic [2:0] REG_DELAY_UNIT = 3'd0;  // register 0, byte address 0
    localparam int         QUIET_LIMIT    = 2000;  // cycles with no item moving
    localparam int         HOLD_CYCLES    = 80;    // long receiver hold-off
    localparam int         SWITCHES       = 5;
    localparam int         DEPTH          = 32;

    // ------------------------------------------------------------------
    // clock and block ports
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_item;
    logic        out_valid;
    logic        out_stall;
    t_out        out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors_seen;
    int reports_owed;

    always #5 i_clk = ~i_clk;

    keyboard_macro_player_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    kmp_report_checker #(
        .UNIT_ADDR (REG_DELAY_UNIT)
    ) report_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_errors    (errors_seen),
        .o_pending   (reports_owed)
    );

    // ------------------------------------------------------------------
    // stimulus knobs shared by the sender and the receiver
    // ------------------------------------------------------------------
    bit         idle_on     = 1;   // random idle bursts on both sides
    bit         sender_gaps = 1;   // cleared while the receiver is held off
    bit         hold_ask    = 0;   // receiver: start one long hold-off
    int         delay_cap   = 1;   // largest delay count written into macros
    logic [4:0] levels      = '0;  // switch levels the polls carry

    // what the bench has written into each macro, to patch delays later
    logic [2:0] shadow_kind [0:SWITCHES-1][0:DEPTH-1];
    logic [7:0] shadow_val  [0:SWITCHES-1][0:DEPTH-1];

    // ------------------------------------------------------------------
    // watchdog: ends the run if no item moves on either channel for a while
    // ------------------------------------------------------------------
    int quiet_n = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_n <= 0;
        end else if (quiet_n >= QUIET_LIMIT) begin
            $display("tb_keyboard_macro_player_core: errors");
            $finish;
        end else begin
            quiet_n <= quiet_n + 1;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        int burst;
        hold_left = 0;
        burst     = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_ask) begin
                hold_ask  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(7) == 0) begin
                burst = $urandom_range(11, 1) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // Offer one item, with an optional idle burst ahead of it, and return
    // at the edge that accepts it. Valid stays high into the next item when
    // there is no gap, so it is never dropped and raised in one step.
    task automatic send_item(input t_in it);
        if (idle_on && sender_gaps && $urandom_range(3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge i_clk);
        end
        if (it.action == ACT_WRITE && it.entry_slot < SWITCHES) begin
            shadow_kind[it.entry_slot][it.entry_position] = it.entry_type;
            shadow_val[it.entry_slot][it.entry_position]  = it.entry_value;
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Setup cycle, then access cycle until pready.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering, wait for every predicted report, then let the
    // step stage and output register settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (reports_owed != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Non-write item with junk in the unused fields.
    function automatic t_in event_item(input logic [1:0] act);
        t_in it;
        it               = t_in'($urandom);
        it.action        = act;
        it.switch_levels = levels;
        return it;
    endfunction

    function automatic t_in entry_item(input logic [2:0] slot, input logic [4:0] pos,
                                       input logic [2:0] kind, input logic [7:0] val);
        t_in it;
        it                = t_in'($urandom);
        it.action         = ACT_WRITE;
        it.entry_slot     = slot;
        it.entry_position = pos;
        it.entry_type     = kind;
        it.entry_value    = val;
        return it;
    endfunction

    // Step types weighted toward presses so the six-key report fills up.
    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 25) return ET_DOWN;
        if (r < 45) return ET_UP;
        if (r < 60) return ET_TAP;
        if (r < 68) return ET_DELAY;
        if (r < 74) return ET_PAUSE;
        if (r < 82) return ET_END;
        if (r < 85) return ET_UNPROG;
        return ET_NOP;
    endfunction

    // Keys from a small pool so that repeats and held-key presses happen,
    // with modifiers, usage 0 and arbitrary codes mixed in. Delay counts
    // stay short so macros keep moving.
    function automatic logic [7:0] pick_value(input logic [2:0] kind);
        int r;
        if (kind == ET_DELAY) return 8'($urandom_range(delay_cap));
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r < 3)  return 8'hE0 + 8'($urandom_range(3));
        if (r < 8)  return 8'h04 + 8'($urandom_range(7));
        return 8'($urandom);
    endfunction

    function automatic t_in random_entry();
        logic [2:0] slot;
        logic [2:0] kind;
        // mostly real macros, sometimes a slot beyond the switches (ignored)
        slot = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                        : 3'($urandom_range(SWITCHES - 1));
        kind = pick_kind();
        return entry_item(slot, 5'($urandom), kind, pick_value(kind));
    endfunction

    // Mostly well-formed play: sent/poll pairs that walk a running macro,
    // switch edges that start or resume one, bursts of ticks and program
    // writes; the rest is raw noise.
    task automatic play_random(input int count);
        int  done_n;
        int  r;
        t_in it;
        done_n = 0;
        while (done_n < count) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_item(event_item(ACT_SENT));
                send_item(event_item(ACT_POLL));
                done_n += 2;
            end else if (r < 58) begin
                levels[$urandom_range(SWITCHES - 1)] ^= 1'b1;
                send_item(event_item(ACT_POLL));
                done_n++;
            end else if (r < 66) begin
                levels = 5'($urandom);
                send_item(event_item(ACT_POLL));
                done_n++;
            end else if (r < 80) begin
                repeat ($urandom_range(4, 1)) begin
                    send_item(event_item(ACT_TICK));
                    done_n++;
                end
            end else if (r < 92) begin
                send_item(random_entry());
                done_n++;
            end else begin
                it = t_in'($urandom);
                if (it.action == ACT_WRITE && it.entry_type == ET_DELAY) begin
                    it.entry_value = 8'($urandom_range(delay_cap));
                end
                send_item(it);
                done_n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] unit_pick;

        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_write(REG_DELAY_UNIT, 32'(DEFAULT_UNIT_MS));

        // Fill every program entry first: the store is undefined until
        // written, and any switch may start its macro.
        for (int s = 0; s < SWITCHES; s++) begin
            for (int p = 0; p < DEPTH; p++) begin
                unit_pick = 8'(pick_kind());
                send_item(entry_item(3'(s), 5'(p), unit_pick[2:0],
                                     pick_value(unit_pick[2:0])));
            end
        end

        // Directed: one macro on switch 1 through down, tap, delay, up, pause and end.
        send_item(entry_item(3'd1, 5'd0, ET_DOWN,   8'hE1));  // modifier press
        send_item(entry_item(3'd1, 5'd1, ET_DOWN,   8'h00));  // usage 0 adds nothing
        send_item(entry_item(3'd1, 5'd2, ET_TAP,    8'hFF));
        send_item(entry_item(3'd1, 5'd3, ET_DELAY,  8'hFF));  // longest count
        send_item(entry_item(3'd1, 5'd4, ET_UP,     8'h04));  // key not held
        send_item(entry_item(3'd1, 5'd5, ET_UP,     8'hE1));
        send_item(entry_item(3'd1, 5'd6, ET_PAUSE,  8'h00));
        send_item(entry_item(3'd1, 5'd7, ET_END,    8'h00));
        send_item(entry_item(3'd7, 5'd31, ET_NOP,   8'hFF));  // slot out of range
        send_item(entry_item(3'd5, 5'd0, ET_DOWN,   8'h04));  // slot out of range
        levels = 5'b00010;
        send_item(event_item(ACT_POLL));                      // press edge, step 0
        send_item(event_item(ACT_POLL));                      // no sent yet: holds
        send_item(event_item(ACT_SENT));
        send_item(event_item(ACT_POLL));                      // down of usage 0
        send_item(event_item(ACT_SENT));
        send_item(event_item(ACT_POLL));                      // tap: press half
        send_item(event_item(ACT_SENT));
        send_item(event_item(ACT_POLL));                      // tap: release half
        send_item(event_item(ACT_SENT));
        send_item(event_item(ACT_POLL));                      // delay starts
        send_item(entry_item(3'd1, 5'd3, ET_DELAY, 8'h00));   // rewrite while running
        send_item(event_item(ACT_TICK));
        send_item(event_item(ACT_SENT));
        levels = 5'b10011;                                    // switches 0, 1 and 4 held
        send_item(event_item(ACT_POLL));

        // Phase 1: default unit, with one long receiver hold-off while the
        // sender keeps offering back to back, so the block backs up.
        play_random(130);
        hold_ask    = 1;
        sender_gaps = 0;
        play_random(40);
        sender_gaps = 1;
        play_random(130);
        drain();

        // Phase 2: smallest nonzero unit.
        reg_write(REG_DELAY_UNIT, 32'd1);
        play_random(250);
        drain();

        // Phase 3: largest unit. Shorten every written delay to zero counts
        // first so macros still finish within the phase.
        delay_cap = 0;
        for (int s = 0; s < SWITCHES; s++) begin
            for (int p = 0; p < DEPTH; p++) begin
                if (shadow_kind[s][p] == ET_DELAY && shadow_val[s][p] != 8'h00) begin
                    send_item(entry_item(3'(s), 5'(p), ET_DELAY, 8'h00));
                end
            end
        end
        drain();
        reg_write(REG_DELAY_UNIT, 32'd255);
        play_random(160);
        drain();

        // Phase 4: some unit in between; the sender pauses once midway
        // until every report is back.
        unit_pick = 8'($urandom_range(254, 2));
        delay_cap = (unit_pick <= 8'd20) ? 1 : 0;
        reg_write(REG_DELAY_UNIT, 32'(unit_pick));
        play_random(120);
        drain();
        play_random(120);
        drain();

        // Phase 5: unit back to 1, no idling on either side.
        delay_cap = 1;
        reg_write(REG_DELAY_UNIT, 32'd1);
        idle_on = 0;
        play_random(260);

        drain();
        repeat (10) @(posedge i_clk);
        if (errors_seen == 0) begin
            $display("tb_keyboard_macro_player_core: clean");
        end else begin
            $display("tb_keyboard_macro_player_core: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/kmp_pkg.sv
hdl/kmp_ram.sv
hdl/keyboard_macro_player_core.sv
hdl/kmp_chk.sv
bench/kmp_report_checker.sv
bench/tb_keyboard_macro_player_core.sv
